FILE: rtl/bssd_pkg.sv
// Shared types, codes and reset constants of the bell swing strike detector.
`default_nettype none

package bssd_pkg;

  // Field and register widths
  localparam int CFG_W          = 16;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int TIMER_BITS_DEF = 16;

  // Register reset values
  localparam logic signed [CFG_W-1:0] HAND_THR_RST   = 16'sd11469;
  localparam logic signed [CFG_W-1:0] BACK_THR_RST   = -16'sd9012;
  localparam logic        [CFG_W-1:0] DEBOUNCE_RST   = 16'd100;
  localparam logic        [CFG_W-1:0] LOCKOUT_RST    = 16'd25;
  localparam logic        [CFG_W-1:0] RING_SPACE_RST = 16'd300;

  // Timer slots
  localparam int TMR_MODE   = 0;
  localparam int TMR_STRIKE = 1;
  localparam int TMR_RING   = 2;
  localparam int TMR_BLACK  = 3;
  localparam int TMR_RED    = 4;
  localparam int NUM_TMR    = 5;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LEFT,
    MODE_RIGHT,
    MODE_JOY
  } mode_t;

  typedef enum logic [1:0] {
    RING_NONE,
    RING_LEFT,
    RING_RIGHT
  } ring_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAND_THR,
    CFG_BACK_THR,
    CFG_DEBOUNCE,
    CFG_LOCKOUT,
    CFG_RING_SPACE
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] hand_thr;
    logic signed [CFG_W-1:0] back_thr;
    logic        [CFG_W-1:0] debounce;
    logic        [CFG_W-1:0] lockout;
    logic        [CFG_W-1:0] ring_space;
  } cfg_t;

  typedef struct packed {
    logic                       left_toggle_n;
    logic                       right_toggle_n;
    logic                       black_button_n;
    logic                       red_button_n;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] accel_sample;
  } in_item_t;

  typedef struct packed {
    mode_t                      mode;
    ring_t                      ring_event;
    logic                       black_press;
    logic                       red_press;
    logic                       joy_valid;
    logic signed [SAMPLE_W-1:0] joy_axis;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/bell_swing_strike_detector_core.sv
// Top level of the bell swing strike detector: stream ports, register bank, tick logic.
// Each accepted result is registered in the result register, or first in the skid entry.
// Throughput: one transaction per cycle while in_tready is high; the tick update is a single
// pass of compares and counter steps between the state registers and the result register.
// A one-entry skid behind the result register keeps in_tready high until it fills on a stall.
// Reset: synchronous, active low; clears all state and timers and restores register
// defaults.
`default_nettype none

module bell_swing_strike_detector_core import bssd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [0] left_toggle_n, [1] right_toggle_n, [2] black_button_n, [3] red_button_n,
  // [19:4] accel_sample, [23:20] zero
  input  wire logic [23:0]          in_tdata,
  // [0] sample_valid
  input  wire logic                 in_tuser,
  // Result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [1:0] mode, [3:2] ring_event, [4] black_press, [5] red_press,
  // [21:6] joy_axis, [23:22] zero
  output logic [23:0]               out_tdata,
  // [0] joy_valid
  output logic                      out_tuser,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t     cfg_r;
  in_item_t item;
  result_t  tick_res;
  result_t  out_res;
  logic     item_en;

  // Register bank, written by index
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hand_thr   <= HAND_THR_RST;
      cfg_r.back_thr   <= BACK_THR_RST;
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.lockout    <= LOCKOUT_RST;
      cfg_r.ring_space <= RING_SPACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HAND_THR:   cfg_r.hand_thr   <= cfg_data;
        CFG_BACK_THR:   cfg_r.back_thr   <= cfg_data;
        CFG_DEBOUNCE:   cfg_r.debounce   <= cfg_data;
        CFG_LOCKOUT:    cfg_r.lockout    <= cfg_data;
        CFG_RING_SPACE: cfg_r.ring_space <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the input transaction
  assign item.left_toggle_n  = in_tdata[0];
  assign item.right_toggle_n = in_tdata[1];
  assign item.black_button_n = in_tdata[2];
  assign item.red_button_n   = in_tdata[3];
  assign item.accel_sample   = in_tdata[19:4];
  assign item.sample_valid   = in_tuser;

  assign item_en = in_tvalid && in_tready;

  bssd_tick #(
    .TIMER_BITS (TIMER_BITS)
  ) u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (item_en),
    .item    (item),
    .cfg     (cfg_r),
    .res     (tick_res)
  );

  bssd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_en),
    .push_data (tick_res),
    .can_push  (in_tready),
    .out_vld   (out_tvalid),
    .out_data  (out_res),
    .out_rdy   (out_tready)
  );

  // Pack the result transaction
  assign out_tdata = {2'b00, out_res.joy_axis, out_res.red_press, out_res.black_press,
                      out_res.ring_event, out_res.mode};
  assign out_tuser = out_res.joy_valid;

endmodule

`default_nettype wire

FILE: rtl/bssd_tick.sv
// Per-tick state update: mode debounce, stroke detection, ring queue, buttons and joystick pass-through.
`default_nettype none

module bssd_tick import bssd_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_en,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output result_t       res
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // State
  mode_t                 accepted_mode_r, accepted_mode_nxt;
  logic                  bell_at_hand_r, bell_at_hand_nxt;
  logic [1:0]            pending_rings_r, pending_rings_nxt;
  logic                  black_held_r, black_held_nxt;
  logic                  red_held_r, red_held_nxt;
  logic [TIMER_BITS-1:0] tmr_r   [NUM_TMR];
  logic [TIMER_BITS-1:0] tmr_nxt [NUM_TMR];

  logic [CFG_W-1:0]   lim  [NUM_TMR];
  logic [NUM_TMR-1:0] over;
  logic [NUM_TMR-1:0] clr;

  mode_t      now_mode;
  logic       active;
  logic       stroke_back, stroke_hand, stroke;
  logic [1:0] pend_stroke;
  logic       ring;

  // Limit for each timer and the start-of-tick compare
  always_comb begin
    lim[TMR_MODE]   = cfg.debounce;
    lim[TMR_STRIKE] = cfg.lockout;
    lim[TMR_RING]   = cfg.ring_space;
    lim[TMR_BLACK]  = cfg.debounce;
    lim[TMR_RED]    = cfg.debounce;
    for (int i = 0; i < NUM_TMR; i++) begin
      over[i] = CMP_W'(tmr_r[i]) > CMP_W'(lim[i]);
    end
  end

  // Decode the toggle position
  always_comb begin
    if (!item.left_toggle_n) begin
      now_mode = MODE_LEFT;
    end else if (!item.right_toggle_n) begin
      now_mode = MODE_RIGHT;
    end else begin
      now_mode = MODE_JOY;
    end
  end

  // Main tick update
  always_comb begin
    clr               = '0;
    accepted_mode_nxt = accepted_mode_r;
    bell_at_hand_nxt  = bell_at_hand_r;
    black_held_nxt    = black_held_r;
    red_held_nxt      = red_held_r;
    res               = '0;

    // Accept a mode change once it has outlasted the debounce time
    if (now_mode != accepted_mode_r) begin
      if (over[TMR_MODE]) begin
        accepted_mode_nxt = now_mode;
      end
    end else begin
      clr[TMR_MODE] = 1'b1;
    end
    active = accepted_mode_nxt != MODE_NONE;

    // Stroke detection with hysteresis and lockout
    stroke_back = bell_at_hand_r && (item.accel_sample <= cfg.back_thr);
    stroke_hand = !bell_at_hand_r && (item.accel_sample >= cfg.hand_thr);
    stroke      = active && item.sample_valid && (accepted_mode_nxt != MODE_JOY) &&
                  over[TMR_STRIKE] && (stroke_back || stroke_hand);
    if (stroke) begin
      clr[TMR_STRIKE]  = 1'b1;
      bell_at_hand_nxt = !bell_at_hand_r;
    end
    pend_stroke = (stroke && pending_rings_r != 2'd3) ? pending_rings_r + 2'd1
                                                      : pending_rings_r;

    // Joystick pass-through
    if (active && item.sample_valid && accepted_mode_nxt == MODE_JOY) begin
      res.joy_valid = 1'b1;
      res.joy_axis  = item.accel_sample;
    end

    // Release one queued ring, keep at most one behind it
    ring = active && (pend_stroke != 2'd0) && over[TMR_RING];
    if (ring) begin
      clr[TMR_RING]     = 1'b1;
      pending_rings_nxt = (pend_stroke >= 2'd2) ? 2'd1 : pend_stroke - 2'd1;
      unique case (accepted_mode_nxt)
        MODE_LEFT:  res.ring_event = RING_LEFT;
        MODE_RIGHT: res.ring_event = RING_RIGHT;
        default:    res.ring_event = RING_NONE;
      endcase
    end else begin
      pending_rings_nxt = pend_stroke;
    end

    // Buttons: one press per hold, locked out by the debounce time
    if (active) begin
      if (!item.black_button_n) begin
        if (!black_held_r && over[TMR_BLACK]) begin
          black_held_nxt  = 1'b1;
          res.black_press = 1'b1;
          clr[TMR_BLACK]  = 1'b1;
        end
      end else begin
        black_held_nxt = 1'b0;
      end
      if (!item.red_button_n) begin
        if (!red_held_r && over[TMR_RED]) begin
          red_held_nxt  = 1'b1;
          res.red_press = 1'b1;
          clr[TMR_RED]  = 1'b1;
        end
      end else begin
        red_held_nxt = 1'b0;
      end
    end

    res.mode = accepted_mode_nxt;

    // Advance the timers, saturating at all ones
    for (int i = 0; i < NUM_TMR; i++) begin
      if (clr[i]) begin
        tmr_nxt[i] = '0;
      end else if (&tmr_r[i]) begin
        tmr_nxt[i] = tmr_r[i];
      end else begin
        tmr_nxt[i] = tmr_r[i] + TIMER_BITS'(1);
      end
    end
  end

  // Commit the state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_mode_r <= MODE_NONE;
      bell_at_hand_r  <= 1'b0;
      pending_rings_r <= 2'd0;
      black_held_r    <= 1'b0;
      red_held_r      <= 1'b0;
      for (int i = 0; i < NUM_TMR; i++) begin
        tmr_r[i] <= '0;
      end
    end else if (item_en) begin
      accepted_mode_r <= accepted_mode_nxt;
      bell_at_hand_r  <= bell_at_hand_nxt;
      pending_rings_r <= pending_rings_nxt;
      black_held_r    <= black_held_nxt;
      red_held_r      <= red_held_nxt;
      for (int i = 0; i < NUM_TMR; i++) begin
        tmr_r[i] <= tmr_nxt[i];
      end
    end
  end

  // Once a mode is accepted the block never falls back to none
  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accepted_mode_r != MODE_NONE |=> accepted_mode_r != MODE_NONE)
    else $error("accepted mode returned to none");

  // A ring restarts the spacing timer
  a_ring_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && res.ring_event != RING_NONE |=> tmr_r[TMR_RING] == '0)
    else $error("ring timer not cleared after a ring");

  // A press marks the button as held
  a_black_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && res.black_press |=> black_held_r)
    else $error("black button not held after a press");

  // Nothing but the mode leaves the block before a mode is accepted
  a_quiet_none: assert property (@(posedge clk) disable iff (!rst_n)
    res.mode == MODE_NONE |-> res.ring_event == RING_NONE && !res.joy_valid &&
                              !res.black_press && !res.red_press)
    else $error("event issued with no accepted mode");

endmodule

`default_nettype wire

FILE: rtl/bssd_outbuf.sv
// Result register with one skid entry, so input acceptance survives a stalled output.
`default_nettype none

module bssd_outbuf import bssd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_push,
  output logic         out_vld,
  output result_t      out_data,
  input  wire logic    out_rdy
);

  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop      = out_vld_r && out_rdy;
  assign can_push = !skid_vld_r;
  assign out_vld  = out_vld_r;
  assign out_data = out_r;

  // Refill the output slot from the skid entry first, then from new data
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || pop) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        out_nxt     = push_data;
        out_vld_nxt = 1'b1;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // The skid entry only fills behind a waiting result
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output slot");

  // A push never arrives while both entries are occupied
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_vld_r)
    else $error("push into a full result buffer");

  // A full buffer with a stalled output keeps its skid entry
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_rdy |=> skid_vld_r)
    else $error("skid entry lost while output stalled");

endmodule

`default_nettype wire
